@@ sv/isc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_pkg: shared types for the indexed sequence store
// Command codes, result status codes, the per-cell update mode and the
// summary that the command decoder hands to the top level.
// ----------------------------------------------------------------------------
package isc_pkg;

  // Command carried in the action field
  typedef enum logic [2:0] {
    ACT_GET        = 3'd0,
    ACT_SET        = 3'd1,
    ACT_INSERT     = 3'd2,
    ACT_REMOVE     = 3'd3,
    ACT_PUSH_FRONT = 3'd4,
    ACT_PUSH_BACK  = 3'd5,
    ACT_POP_FRONT  = 3'd6,
    ACT_POP_BACK   = 3'd7
  } act_t;

  // Result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell of the row does this cycle
  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  // Decoder summary for the result beat
  typedef struct packed {
    status_t status;
    logic    rd_en;
  } resp_t;

  localparam int unsigned ACT_BITS    = 3;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned PORT_ELEM_BITS = 32;

endpackage

@@ sv/indexed_sequence_store_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_store_core: ordered element store with indexed access
// Row of element cells plus a command decoder and one output register.
// ----------------------------------------------------------------------------
// Use:
//   in_* beats carry one command (get, set, insert, remove, push or pop at
//   either end). Each command yields exactly one out_* beat with the element
//   read (gets only), a status and the element count after the command.
//   The command is decoded and applied to the row of cells in the cycle it is
//   accepted; every cell shifts or loads at once, whatever the position.
//   The result beat appears on the next cycle, and one command is taken per
//   cycle while out_tready lets the output register drain.
//   The output register is the only buffer: while a result waits and
//   out_tready is low, in_tready is low; a result taken in the same cycle
//   frees the slot for the next command.
//   Reset empties the store (count zero) and drops any pending result;
//   element slots are not cleared and are only read below the count.
// ----------------------------------------------------------------------------
module indexed_sequence_store_core #(
  parameter int unsigned CAPACITY     = 16,
  parameter int unsigned ELEMENT_BITS = 32,
  localparam int unsigned IDX_W  = $clog2(CAPACITY + 1),
  localparam int unsigned IN_W   = isc_pkg::ACT_BITS + IDX_W + isc_pkg::PORT_ELEM_BITS,
  localparam int unsigned IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W  = isc_pkg::PORT_ELEM_BITS + isc_pkg::STATUS_BITS + IDX_W,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // action, position, element_in (from bit 0 up), zero padding on top
  input  logic [IN_TW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // element_out, status, count (from bit 0 up), zero padding on top
  output logic [OUT_TW-1:0] out_tdata
);

  localparam int unsigned PE = isc_pkg::PORT_ELEM_BITS;
  localparam int unsigned AB = isc_pkg::ACT_BITS;

  // Input fields
  isc_pkg::act_t            action;
  logic [IDX_W-1:0]         position;
  logic [PE-1:0]            element_in;
  logic [ELEMENT_BITS-1:0]  wr_data;

  assign action     = isc_pkg::act_t'(in_tdata[AB-1:0]);
  assign position   = in_tdata[AB +: IDX_W];
  assign element_in = in_tdata[AB + IDX_W +: PE];
  assign wr_data    = ELEMENT_BITS'(element_in);

  logic fire;
  logic out_valid_r;

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  // Command decode
  logic [IDX_W-1:0] count_r;
  logic [IDX_W-1:0] count_nxt;
  logic [IDX_W-1:0] pos_eff;
  isc_pkg::mode_t   mode;
  isc_pkg::resp_t   resp;

  isc_decode #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_decode (
    .fire     (fire),
    .action   (action),
    .position (position),
    .cnt      (count_r),
    .mode     (mode),
    .pos_eff  (pos_eff),
    .cnt_nxt  (count_nxt),
    .resp     (resp)
  );

  // Row of cells, neighbors wired both ways
  logic [ELEMENT_BITS-1:0] cell_q [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left_q;
    logic [ELEMENT_BITS-1:0] right_q;
    if (g == 0) begin : g_first
      assign left_q = wr_data;
    end else begin : g_mid_l
      assign left_q = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_q = cell_q[g];
    end else begin : g_mid_r
      assign right_q = cell_q[g+1];
    end
    isc_cell #(
      .ELEM_W (ELEMENT_BITS),
      .IDX_W  (IDX_W),
      .SLOT   (g)
    ) u_cell (
      .clk     (clk),
      .mode    (mode),
      .pos     (pos_eff),
      .wr_data (wr_data),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[g])
    );
  end

  // Read select for get
  logic [ELEMENT_BITS-1:0] rd_data;
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (IDX_W'(i) == position) rd_data = cell_q[i];
    end
  end

  // Result register
  logic [PE-1:0]        elem_out_r;
  logic [PE-1:0]        elem_out_nxt;
  isc_pkg::status_t     status_r;

  assign elem_out_nxt = resp.rd_en ? PE'(rd_data) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      elem_out_r <= elem_out_nxt;
      status_r   <= resp.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({count_r, status_r, elem_out_r});

endmodule

@@ sv/isc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_cell: one element slot of the store
// Holds one element and, on a shift, takes its left or right neighbor's
// value so that the cells from the command position up move by one place.
// ----------------------------------------------------------------------------
module isc_cell #(
  parameter int unsigned ELEM_W = 32,
  parameter int unsigned IDX_W  = 5,
  parameter int unsigned SLOT   = 0
) (
  input  logic              clk,
  input  isc_pkg::mode_t    mode,
  input  logic [IDX_W-1:0]  pos,
  input  logic [ELEM_W-1:0] wr_data,
  input  logic [ELEM_W-1:0] left_q,
  input  logic [ELEM_W-1:0] right_q,
  output logic [ELEM_W-1:0] q
);

  logic [ELEM_W-1:0] data_r;
  logic [ELEM_W-1:0] data_nxt;
  logic [IDX_W-1:0]  slot_idx;
  logic              at_pos;
  logic              above_pos;

  assign slot_idx  = IDX_W'(SLOT);
  assign at_pos    = (slot_idx == pos);
  assign above_pos = (slot_idx > pos);

  // Next value by mode and place relative to the command position
  always_comb begin
    data_nxt = data_r;
    unique case (mode)
      isc_pkg::MODE_HOLD:   data_nxt = data_r;
      isc_pkg::MODE_WRITE:  if (at_pos) data_nxt = wr_data;
      isc_pkg::MODE_INSERT: begin
        if (at_pos) data_nxt = wr_data;
        else if (above_pos) data_nxt = left_q;
      end
      isc_pkg::MODE_REMOVE: if (at_pos || above_pos) data_nxt = right_q;
      default:              data_nxt = data_r;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

@@ sv/isc_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_decode: command decoder
// Checks a command against the element count, picks the effective position,
// the row mode and the next count, and forms the result status.
// ----------------------------------------------------------------------------
module isc_decode #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDX_W    = 5
) (
  input  logic             fire,
  input  isc_pkg::act_t    action,
  input  logic [IDX_W-1:0] position,
  input  logic [IDX_W-1:0] cnt,
  output isc_pkg::mode_t   mode,
  output logic [IDX_W-1:0] pos_eff,
  output logic [IDX_W-1:0] cnt_nxt,
  output isc_pkg::resp_t   resp
);

  logic             full;
  logic             empty;
  logic             in_range;
  logic [IDX_W-1:0] ins_pos;
  logic [IDX_W-1:0] last_idx;

  assign full     = (cnt == IDX_W'(CAPACITY));
  assign empty    = (cnt == '0);
  assign in_range = (position < cnt);
  assign ins_pos  = empty ? '0 : position;
  assign last_idx = cnt - IDX_W'(1);

  always_comb begin
    mode        = isc_pkg::MODE_HOLD;
    pos_eff     = position;
    cnt_nxt     = cnt;
    resp.status = isc_pkg::ST_OK;
    resp.rd_en  = 1'b0;
    unique case (action)
      isc_pkg::ACT_GET: begin
        if (in_range) resp.rd_en = 1'b1;
        else resp.status = isc_pkg::ST_RANGE;
      end
      isc_pkg::ACT_SET: begin
        if (in_range) mode = isc_pkg::MODE_WRITE;
        else resp.status = isc_pkg::ST_RANGE;
      end
      isc_pkg::ACT_INSERT: begin
        pos_eff = ins_pos;
        if (full) resp.status = isc_pkg::ST_FULL;
        else if (ins_pos > cnt) resp.status = isc_pkg::ST_RANGE;
        else begin
          mode    = isc_pkg::MODE_INSERT;
          cnt_nxt = cnt + IDX_W'(1);
        end
      end
      isc_pkg::ACT_REMOVE: begin
        if (in_range) begin
          mode    = isc_pkg::MODE_REMOVE;
          cnt_nxt = last_idx;
        end else resp.status = isc_pkg::ST_RANGE;
      end
      isc_pkg::ACT_PUSH_FRONT, isc_pkg::ACT_PUSH_BACK: begin
        pos_eff = (action == isc_pkg::ACT_PUSH_FRONT) ? '0 : cnt;
        if (full) resp.status = isc_pkg::ST_FULL;
        else begin
          mode    = isc_pkg::MODE_INSERT;
          cnt_nxt = cnt + IDX_W'(1);
        end
      end
      isc_pkg::ACT_POP_FRONT, isc_pkg::ACT_POP_BACK: begin
        pos_eff = (action == isc_pkg::ACT_POP_FRONT) ? '0 : last_idx;
        if (empty) resp.status = isc_pkg::ST_RANGE;
        else begin
          mode    = isc_pkg::MODE_REMOVE;
          cnt_nxt = last_idx;
        end
      end
      default: resp.status = isc_pkg::ST_RANGE;
    endcase
    // No change to the row unless the beat is taken
    if (!fire) mode = isc_pkg::MODE_HOLD;
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for indexed_sequence_store_core
// Drives command beats into the store and tracks its own copy of the element
// sequence. Every result beat is compared field by field with the reply that
// this copy predicts. A directed opening covers the empty and full store, both
// ends and the out-of-range indexes. Random traffic follows, in fill, drain
// and mixed phases, with random idling on both sides and one long
// back-pressure stall.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned RAND_ITEMS = 1520;

  // Expected content of one result beat
  typedef struct {
    logic [31:0]      element;
    isc_pkg::status_t status;
    logic [4:0]       count;
  } reply_t;

  // Shadow copy of the sequence plus the replies still owed by the block
  class store_tracker;
    logic [31:0] cells [DEPTH];
    int unsigned held;
    reply_t      due [$];
    int unsigned errors;
    int unsigned replies;

    function new();
      held    = 0;
      errors  = 0;
      replies = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    // Open a slot at pos and write v there; later elements move up
    function isc_pkg::status_t place(int unsigned pos, logic [31:0] v);
      if (held >= DEPTH) return isc_pkg::ST_FULL;
      if (held == 0) pos = 0;
      if (pos > held) return isc_pkg::ST_RANGE;
      for (int unsigned i = held; i > pos; i--) cells[i] = cells[i-1];
      cells[pos] = v;
      held++;
      return isc_pkg::ST_OK;
    endfunction

    // Close the slot at pos; later elements move down
    function isc_pkg::status_t take(int unsigned pos);
      if (pos >= held) return isc_pkg::ST_RANGE;
      for (int unsigned i = pos; i + 1 < held; i++) cells[i] = cells[i+1];
      held--;
      return isc_pkg::ST_OK;
    endfunction

    // Apply one accepted command beat and queue the reply it causes
    function void note_command(isc_pkg::act_t act, logic [4:0] pos, logic [31:0] v);
      reply_t r;
      r.element = '0;
      r.status  = isc_pkg::ST_OK;
      case (act)
        isc_pkg::ACT_GET: begin
          if (pos < held) r.element = cells[pos];
          else r.status = isc_pkg::ST_RANGE;
        end
        isc_pkg::ACT_SET: begin
          if (pos < held) cells[pos] = v;
          else r.status = isc_pkg::ST_RANGE;
        end
        isc_pkg::ACT_INSERT:     r.status = place(pos, v);
        isc_pkg::ACT_REMOVE:     r.status = take(pos);
        isc_pkg::ACT_PUSH_FRONT: r.status = place(0, v);
        isc_pkg::ACT_PUSH_BACK:  r.status = place(held, v);
        isc_pkg::ACT_POP_FRONT:  r.status = (held == 0) ? isc_pkg::ST_RANGE : take(0);
        default:                 r.status = (held == 0) ? isc_pkg::ST_RANGE : take(held - 1);
      endcase
      r.count = held[4:0];
      due.push_back(r);
    endfunction

    // Compare one accepted result beat with the oldest queued reply
    function void check_reply(logic [39:0] beat);
      reply_t r;
      replies++;
      if (due.size() == 0) begin
        $error("unexpected result beat %h", beat);
        errors++;
        return;
      end
      r = due.pop_front();
      if (beat[31:0] !== r.element) begin
        $error("element_out: expected %h, got %h", r.element, beat[31:0]);
        errors++;
      end
      if (beat[33:32] !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, beat[33:32]);
        errors++;
      end
      if (beat[38:34] !== r.count) begin
        $error("count: expected %0d, got %0d", r.count, beat[38:34]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  store_tracker tracker = new();
  int unsigned  sent;

  indexed_sequence_store_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Idling is off in a quiet window of the run
  function automatic bit quiet(int unsigned n);
    return (n >= 700) && (n < 1000);
  endfunction

  // Offer one command beat and wait until it is taken
  task automatic send_cmd(isc_pkg::act_t act, logic [4:0] pos, logic [31:0] v);
    if (!quiet(sent) && $urandom_range(0, 99) < 8) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {v, pos, act};
    do @(posedge clk); while (!in_tready);
    tracker.note_command(act, pos, v);
    sent++;
  endtask

  // Random element value, with the extremes now and then
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Random command, biased by phase so the store swings between empty and full
  task automatic send_random(int unsigned n);
    isc_pkg::act_t act;
    int unsigned   phase;
    int unsigned   lim;
    logic [4:0]    pos;
    phase = (n / 120) % 3;
    if (phase == 0 && $urandom_range(0, 99) < 60)
      act = isc_pkg::act_t'(
              $urandom_range(isc_pkg::ACT_INSERT, isc_pkg::ACT_PUSH_BACK) ==
              isc_pkg::ACT_REMOVE ? isc_pkg::ACT_INSERT :
              $urandom_range(isc_pkg::ACT_INSERT, isc_pkg::ACT_PUSH_BACK));
    else if (phase == 1 && $urandom_range(0, 99) < 60)
      act = isc_pkg::act_t'($urandom_range(0, 2) == 0 ? isc_pkg::ACT_REMOVE :
              $urandom_range(isc_pkg::ACT_POP_FRONT, isc_pkg::ACT_POP_BACK));
    else
      act = isc_pkg::act_t'($urandom_range(0, 7));
    // Mostly a valid index, sometimes anything from 0 to DEPTH
    lim = (act == isc_pkg::ACT_INSERT) ? tracker.held : tracker.held - 1;
    if (tracker.held > 0 && $urandom_range(0, 99) < 80)
      pos = 5'($urandom_range(0, lim));
    else
      pos = 5'($urandom_range(0, DEPTH));
    send_cmd(act, pos, pick_value());
  endtask

  // Stimulus
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    sent      = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty store: every read and take fails
    send_cmd(isc_pkg::ACT_GET,        5'd0,  32'h0);
    send_cmd(isc_pkg::ACT_POP_FRONT,  5'd0,  32'h0);
    send_cmd(isc_pkg::ACT_POP_BACK,   5'd0,  32'h0);
    send_cmd(isc_pkg::ACT_REMOVE,     5'd0,  32'h0);
    send_cmd(isc_pkg::ACT_SET,        5'd0,  32'h1);
    // Insert into empty ignores the index
    send_cmd(isc_pkg::ACT_INSERT,     5'd16, 32'hFFFF_FFFF);
    // Past the end, then exactly at the end
    send_cmd(isc_pkg::ACT_INSERT,     5'd3,  32'h1111_1111);
    send_cmd(isc_pkg::ACT_INSERT,     5'd1,  32'h0000_0000);
    send_cmd(isc_pkg::ACT_PUSH_FRONT, 5'd31, 32'h1234_5678);
    send_cmd(isc_pkg::ACT_PUSH_BACK,  5'd0,  32'hA5A5_A5A5);
    send_cmd(isc_pkg::ACT_INSERT,     5'd2,  32'h5A5A_5A5A);
    send_cmd(isc_pkg::ACT_GET,        5'd2,  32'h0);
    send_cmd(isc_pkg::ACT_GET,        5'd5,  32'h0);
    send_cmd(isc_pkg::ACT_SET,        5'd4,  32'h0000_0001);
    send_cmd(isc_pkg::ACT_SET,        5'd5,  32'h0000_0002);
    // Fill up, then push and insert into the full store
    while (tracker.held < DEPTH) send_cmd(isc_pkg::ACT_PUSH_BACK, 5'd0, $urandom());
    send_cmd(isc_pkg::ACT_PUSH_FRONT, 5'd0,  32'hDEAD_0001);
    send_cmd(isc_pkg::ACT_INSERT,     5'd3,  32'hDEAD_0002);
    send_cmd(isc_pkg::ACT_PUSH_BACK,  5'd0,  32'hDEAD_0003);
    send_cmd(isc_pkg::ACT_GET,        5'd15, 32'h0);
    send_cmd(isc_pkg::ACT_GET,        5'd16, 32'h0);
    send_cmd(isc_pkg::ACT_REMOVE,     5'd16, 32'h0);
    send_cmd(isc_pkg::ACT_REMOVE,     5'd7,  32'h0);
    send_cmd(isc_pkg::ACT_POP_FRONT,  5'd9,  32'h0);
    send_cmd(isc_pkg::ACT_POP_BACK,   5'd0,  32'h0);

    for (int unsigned n = 0; n < RAND_ITEMS; n++) send_random(n);

    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain, then let the output register settle
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, check every beat taken
  initial begin
    int unsigned hold;
    bit          held_off;
    out_tready = 1'b0;
    held_off   = 1'b0;
    hold       = 0;
    forever begin
      @(negedge clk);
      if (!held_off && tracker.replies == 400) begin
        held_off = 1'b1;
        hold     = 300;
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else if (quiet(tracker.replies)) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 8);
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_reply(out_tdata);
    end
  end

  // Watchdog
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ indexed_sequence_store_core.f @@
sv/isc_pkg.sv
sv/isc_cell.sv
sv/isc_decode.sv
sv/indexed_sequence_store_core.sv
sim/testbench.sv
